// ----- sv/load_average_ewma_macros.svh -----
// assertion macros shared by the load average modules
// expects clock and reset signals in the scope of each use
`ifndef LOAD_AVERAGE_EWMA_MACROS_SVH
`define LOAD_AVERAGE_EWMA_MACROS_SVH

// condition implies expression in the same cycle
`define LAE_ASSERT_NOW(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// condition implies expression in the next cycle
`define LAE_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ----- sv/lae_pkg.sv -----
// shared types, widths and constants of the load average block
// used by the channel interfaces, controller, datapath and top level
package lae_pkg;

   localparam int NowW      = 32;
   localparam int TaskW     = 16;
   localparam int WantW     = 8;
   localparam int LoadW     = 32;
   localparam int CountW    = 2;
   localparam int IntervalW = 8;

   localparam logic [IntervalW-1:0] IntervalReset = 8'd5;
   localparam logic [CountW-1:0]    MaxCount      = 2'd3;
   localparam logic [1:0]           LaneLast      = 2'd2;

   localparam logic [32:0] QOne  = 33'h1_0000_0000;
   localparam logic [63:0] QHalf = 64'h0000_0000_8000_0000;

   // multiplier operand select
   localparam logic [1:0] MulAccSq = 2'd0;
   localparam logic [1:0] MulSqSq  = 2'd1;
   localparam logic [1:0] MulAvgF  = 2'd2;
   localparam logic [1:0] MulTgtCf = 2'd3;

   typedef struct packed {
      logic       accept;
      logic       lane_init;
      logic       lane_step;
      logic       bit_step;
      logic [1:0] mul_sel;
      logic       load_acc;
      logic       load_sq;
      logic       sum_load;
      logic       avg_write;
      logic       rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_update;
      logic big;
      logic bit_set;
      logic bit_last;
      logic lane_last;
      logic rsp_free;
   } dp_status_type;

   // per-second decay factors in q0.32 for 60, 300 and 900 second windows
   function automatic logic [31:0] per_second(input logic [1:0] lane);
      logic [31:0] f;
      case (lane)
         2'd0:    f = 32'd4223977731;
         2'd1:    f = 32'd4280674573;
         default: f = 32'd4290197760;
      endcase
      return f;
   endfunction

endpackage

// ----- sv/lae_req_if.sv -----
// request channel: time stamp, task count and averages asked for
// depends on lae_pkg for field widths
interface lae_req_if;
   logic                       valid;
   logic                       ready;
   logic [lae_pkg::NowW-1:0]   now_seconds;
   logic [lae_pkg::TaskW-1:0]  task_count;
   logic [lae_pkg::WantW-1:0]  count_wanted;

   modport source(output valid, now_seconds, task_count, count_wanted, input ready);
   modport sink(input valid, now_seconds, task_count, count_wanted, output ready);
endinterface

// ----- sv/lae_rsp_if.sv -----
// response channel: three averages, count given and update flag
// depends on lae_pkg for field widths
interface lae_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [lae_pkg::LoadW-1:0]  load_one;
   logic [lae_pkg::LoadW-1:0]  load_five;
   logic [lae_pkg::LoadW-1:0]  load_fifteen;
   logic [lae_pkg::CountW-1:0] count_given;
   logic                       was_updated;

   modport source(output valid, load_one, load_five, load_fifteen, count_given, was_updated,
                  input ready);
   modport sink(input valid, load_one, load_five, load_fifteen, count_given, was_updated,
                output ready);
endinterface

// ----- sv/lae_ctrl.sv -----
// controller state machine sequencing exponentiation and average mixing
// depends on lae_pkg and load_average_ewma_macros.svh
`include "load_average_ewma_macros.svh"

module lae_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lae_pkg::dp_status_type status,
   output lae_pkg::ctrl_cmd_type  cmd
);

   localparam logic [3:0] StIdle   = 4'd0;
   localparam logic [3:0] StInit   = 4'd1;
   localparam logic [3:0] StExpMa  = 4'd2;
   localparam logic [3:0] StExpMs  = 4'd3;
   localparam logic [3:0] StExpLs  = 4'd4;
   localparam logic [3:0] StMixA   = 4'd5;
   localparam logic [3:0] StMixB   = 4'd6;
   localparam logic [3:0] StMixC   = 4'd7;
   localparam logic [3:0] StFinish = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.mul_sel = lae_pkg::MulAccSq;
      req_ready = 1'b0;
      case (state_ff)
         StIdle: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = status.req_update ? StInit : StFinish;
            end
         end
         StInit: begin
            cmd.lane_init = 1'b1;
            state_in      = status.big ? StMixA : StExpMa;
         end
         StExpMa: begin
            cmd.mul_sel = lae_pkg::MulAccSq;
            state_in    = StExpMs;
         end
         StExpMs: begin
            cmd.mul_sel  = lae_pkg::MulSqSq;
            cmd.load_acc = status.bit_set;
            state_in     = status.bit_last ? StMixA : StExpLs;
         end
         StExpLs: begin
            cmd.load_sq  = 1'b1;
            cmd.bit_step = 1'b1;
            state_in     = StExpMa;
         end
         StMixA: begin
            cmd.mul_sel = lae_pkg::MulAvgF;
            state_in    = StMixB;
         end
         StMixB: begin
            cmd.mul_sel  = lae_pkg::MulTgtCf;
            cmd.sum_load = 1'b1;
            state_in     = StMixC;
         end
         StMixC: begin
            cmd.avg_write = 1'b1;
            if (status.lane_last) begin
               state_in = StFinish;
            end else begin
               cmd.lane_step = 1'b1;
               state_in      = StInit;
            end
         end
         StFinish: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
   end

   `LAE_ASSERT_NOW(a_rsp_load_free, cmd.rsp_load, status.rsp_free, "response loaded while slot busy")
   `LAE_ASSERT_NEXT(a_accept_leaves_idle, req_valid && req_ready, state_ff != StIdle, "stayed idle after accept")

endmodule

// ----- sv/lae_datapath.sv -----
// datapath: interval check, shared 32x32 multiplier, averages and response register
// depends on lae_pkg and load_average_ewma_macros.svh
`include "load_average_ewma_macros.svh"

module lae_datapath #(
   parameter int FRAC_BITS  = 16,
   parameter int DELTA_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [lae_pkg::IntervalW-1:0]      csr_write_data,
   input  logic [lae_pkg::NowW-1:0]           req_now_seconds,
   input  logic [lae_pkg::TaskW-1:0]          req_task_count,
   input  logic [lae_pkg::WantW-1:0]          req_count_wanted,
   input  lae_pkg::ctrl_cmd_type              cmd,
   output lae_pkg::dp_status_type             status,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic [lae_pkg::LoadW-1:0]          rsp_load_one,
   output logic [lae_pkg::LoadW-1:0]          rsp_load_five,
   output logic [lae_pkg::LoadW-1:0]          rsp_load_fifteen,
   output logic [lae_pkg::CountW-1:0]         rsp_count_given,
   output logic                               rsp_was_updated
);

   localparam int          CntW     = $clog2(DELTA_BITS);
   localparam logic [32:0] DeltaMax = (33'd1 << DELTA_BITS) - 33'd1;

   logic [lae_pkg::IntervalW-1:0] interval_ff, interval_in;
   logic [31:0]                   last_update_ff, last_update_in;
   logic [DELTA_BITS-1:0]         delta_ff, delta_in;
   logic                          big_ff, big_in;
   logic [31:0]                   target_ff, target_in;
   logic [lae_pkg::CountW-1:0]    given_ff, given_in;
   logic                          updated_ff, updated_in;
   logic [1:0]                    lane_ff, lane_in;
   logic [CntW-1:0]               bit_ff, bit_in;
   logic [32:0]                   acc_ff, acc_in;
   logic [31:0]                   sq_ff, sq_in;
   logic [63:0]                   prod_ff, prod_in;
   logic [63:0]                   sum_ff, sum_in;
   logic [31:0]                   avg_ff [3];
   logic [31:0]                   avg_in [3];
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [31:0]                   one_ff, one_in;
   logic [31:0]                   five_ff, five_in;
   logic [31:0]                   fifteen_ff, fifteen_in;
   logic [lae_pkg::CountW-1:0]    count_ff, count_in;
   logic                          was_ff, was_in;

   logic [31:0] delta;
   logic        update;
   logic [47:0] tgt_wide;
   logic [31:0] mul_a;
   logic [32:0] mul_b;
   logic [63:0] raw_prod;
   logic [63:0] rnd;
   logic [63:0] total;

   // elapsed time and interval test
   always_comb begin
      delta    = req_now_seconds - last_update_ff;
      update   = !delta[31] && (delta >= {24'd0, interval_ff});
      tgt_wide = {32'd0, req_task_count} << FRAC_BITS;
   end

   // shared multiplier, b operand at most 1.0 in q1.32
   always_comb begin
      case (cmd.mul_sel)
         lae_pkg::MulAccSq: begin
            mul_a = sq_ff;
            mul_b = acc_ff;
         end
         lae_pkg::MulSqSq: begin
            mul_a = sq_ff;
            mul_b = {1'b0, sq_ff};
         end
         lae_pkg::MulAvgF: begin
            mul_a = avg_ff[lane_ff];
            mul_b = acc_ff;
         end
         default: begin
            mul_a = target_ff;
            mul_b = lae_pkg::QOne - acc_ff;
         end
      endcase
      raw_prod = mul_a * mul_b[31:0];
      prod_in  = mul_b[32] ? {mul_a, 32'd0} : raw_prod;
      rnd      = prod_ff + lae_pkg::QHalf;
      total    = sum_ff + prod_ff;
   end

   always_comb begin
      interval_in    = csr_write_en ? csr_write_data : interval_ff;
      last_update_in = last_update_ff;
      delta_in       = delta_ff;
      big_in         = big_ff;
      target_in      = target_ff;
      given_in       = given_ff;
      updated_in     = updated_ff;
      lane_in        = lane_ff;
      bit_in         = bit_ff;
      acc_in         = acc_ff;
      sq_in          = sq_ff;
      sum_in         = sum_ff;
      avg_in         = avg_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      one_in         = one_ff;
      five_in        = five_ff;
      fifteen_in     = fifteen_ff;
      count_in       = count_ff;
      was_in         = was_ff;

      if (cmd.accept) begin
         updated_in = update;
         delta_in   = delta[DELTA_BITS-1:0];
         big_in     = {1'b0, delta} > DeltaMax;
         target_in  = (|tgt_wide[47:32]) ? 32'hFFFF_FFFF : tgt_wide[31:0];
         given_in   = (req_count_wanted > {6'd0, lae_pkg::MaxCount}) ?
                      lae_pkg::MaxCount : req_count_wanted[1:0];
         lane_in    = 2'd0;
         if (update) begin
            last_update_in = req_now_seconds;
         end
      end
      if (cmd.lane_init) begin
         acc_in = big_ff ? 33'd0 : lae_pkg::QOne;
         sq_in  = lae_pkg::per_second(lane_ff);
         bit_in = '0;
      end
      if (cmd.lane_step) begin
         lane_in = lane_ff + 2'd1;
      end
      if (cmd.bit_step) begin
         bit_in = bit_ff + CntW'(1);
      end
      if (cmd.load_acc) begin
         acc_in = {1'b0, rnd[63:32]};
      end
      if (cmd.load_sq) begin
         sq_in = rnd[63:32];
      end
      if (cmd.sum_load) begin
         sum_in = rnd;
      end
      if (cmd.avg_write) begin
         avg_in[lane_ff] = total[63:32];
      end
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         one_in       = (given_ff != 2'd0) ? avg_ff[0] : 32'd0;
         five_in      = (given_ff > 2'd1) ? avg_ff[1] : 32'd0;
         fifteen_in   = (given_ff == lae_pkg::MaxCount) ? avg_ff[2] : 32'd0;
         count_in     = given_ff;
         was_in       = updated_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff    <= lae_pkg::IntervalReset;
         last_update_ff <= 32'd0;
         avg_ff[0]      <= 32'd0;
         avg_ff[1]      <= 32'd0;
         avg_ff[2]      <= 32'd0;
         lane_ff        <= 2'd0;
         bit_ff         <= '0;
         acc_ff         <= lae_pkg::QOne;
         rsp_valid_ff   <= 1'b0;
      end else begin
         interval_ff    <= interval_in;
         last_update_ff <= last_update_in;
         avg_ff         <= avg_in;
         lane_ff        <= lane_in;
         bit_ff         <= bit_in;
         acc_ff         <= acc_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      delta_ff   <= delta_in;
      big_ff     <= big_in;
      target_ff  <= target_in;
      given_ff   <= given_in;
      updated_ff <= updated_in;
      sq_ff      <= sq_in;
      prod_ff    <= prod_in;
      sum_ff     <= sum_in;
      one_ff     <= one_in;
      five_ff    <= five_in;
      fifteen_ff <= fifteen_in;
      count_ff   <= count_in;
      was_ff     <= was_in;
   end

   always_comb begin
      status.req_update = update;
      status.big        = big_ff;
      status.bit_set    = delta_ff[bit_ff];
      status.bit_last   = bit_ff == CntW'(DELTA_BITS - 1);
      status.lane_last  = lane_ff == lae_pkg::LaneLast;
      status.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_load_one     = one_ff;
   assign rsp_load_five    = five_ff;
   assign rsp_load_fifteen = fifteen_ff;
   assign rsp_count_given  = count_ff;
   assign rsp_was_updated  = was_ff;

   `LAE_ASSERT_NOW(a_factor_le_one, acc_ff[32], acc_ff[31:0] == 32'd0, "decay factor above one")
   `LAE_ASSERT_NEXT(a_skip_keeps_time, cmd.accept && !update, $stable(last_update_ff), "update time moved without update")

endmodule

// ----- sv/load_average_ewma.sv -----
// top level of the exponential load average block
// depends on lae_pkg, lae_req_if, lae_rsp_if, lae_ctrl and lae_datapath
//
//  channel   direction  handshake          word
//  req_ch    in         valid/ready        now_seconds, task_count, count_wanted
//  rsp_ch    out        valid/ready        load_one/five/fifteen, count_given, was_updated
//  csr_*     in         write enable only  min_interval
//
// an item that does not update goes from accept to the finish state, which loads the response register
// an updating item runs for each average an exponent walk over the delta bits, skipped when delta
// saturates, and then the mixing steps, all on the single shared 32x32 multiplier
// synchronous reset sets min_interval to 5 and clears the averages and update time
// the response register holds its word under stall; a new item is taken meanwhile
// and waits at its end until the previous word has left
module load_average_ewma #(
   parameter int FRAC_BITS  = 16,
   parameter int DELTA_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [lae_pkg::IntervalW-1:0] csr_write_data,
   lae_req_if.sink                       req_ch,
   lae_rsp_if.source                     rsp_ch
);

   lae_pkg::ctrl_cmd_type  cmd;
   lae_pkg::dp_status_type status;

   lae_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lae_datapath #(
      .FRAC_BITS  (FRAC_BITS),
      .DELTA_BITS (DELTA_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data),
      .req_now_seconds  (req_ch.now_seconds),
      .req_task_count   (req_ch.task_count),
      .req_count_wanted (req_ch.count_wanted),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_load_one     (rsp_ch.load_one),
      .rsp_load_five    (rsp_ch.load_five),
      .rsp_load_fifteen (rsp_ch.load_fifteen),
      .rsp_count_given  (rsp_ch.count_given),
      .rsp_was_updated  (rsp_ch.was_updated)
   );

endmodule
